// File: sv/hlv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_pkg
// Shared constants, trig tables and controller/datapath bundles for the
// Hough line vote and peak block.
// ----------------------------------------------------------------------------
package hlv_pkg;

  // Field widths
  localparam int unsigned COORD_BITS    = 9;
  localparam int unsigned VAL_BITS      = 16;
  localparam int unsigned THETA_BITS    = 4;
  localparam int unsigned RHO_BITS      = 6;
  localparam int unsigned ADDR_BITS     = THETA_BITS + RHO_BITS;
  localparam int unsigned LINES_BITS    = 7;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned STEP_BITS     = 4;

  // Geometry
  localparam int unsigned THETA_BINS    = 16;
  localparam int unsigned RHO_BINS      = 64;
  localparam int unsigned CELLS         = THETA_BINS * RHO_BINS;
  localparam int unsigned IMG_SIZE      = 512;
  localparam int unsigned RESULT_CAP    = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Rho quantization: step 24 in Q14 is 3 * 2^17
  localparam int unsigned RHO_STEP      = 24;
  localparam int unsigned RHO_DEN_SHIFT = 17;
  localparam int unsigned RHO_ROUND     = (RHO_STEP * 16384) / 2;
  localparam int unsigned RECIP3        = 171;
  localparam int unsigned RECIP3_SHIFT  = 9;
  localparam int unsigned RHO_HALF      = RHO_BINS / 2;

  localparam logic [THETA_BITS-1:0] THETA_LAST  = THETA_BITS'(THETA_BINS - 1);
  localparam logic [THETA_BITS-1:0] THETA_INNER = THETA_BITS'(THETA_BINS - 2);
  localparam logic [RHO_BITS-1:0]   RHO_INNER   = RHO_BITS'(RHO_BINS - 2);
  localparam logic [ADDR_BITS-1:0]  ADDR_LAST   = ADDR_BITS'(CELLS - 1);
  localparam logic [STEP_BITS-1:0]  STEP_LAST   = STEP_BITS'(9);

  // Item kinds
  localparam logic KIND_VOTE = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_THRESHOLD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LINES      = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic                  pix_load;
    logic                  find_start;
    logic                  vote_en;
    logic [THETA_BITS-1:0] vote_theta;
    logic                  scan_en;
    logic [STEP_BITS-1:0]  step;
    logic [THETA_BITS-1:0] cell_theta;
    logic [RHO_BITS-1:0]   cell_rho;
    logic                  take_peak;
    logic                  flush;
    logic                  clr_en;
    logic [ADDR_BITS-1:0]  clr_addr;
  } cmd_t;

  typedef struct packed {
    logic peak;
    logic pend_valid;
    logic can_push;
    logic limit_next;
    logic vote_busy;
  } sts_t;

  // cos(pi*t/16) in Q1.14
  function automatic logic signed [15:0] cos_q14(input logic [THETA_BITS-1:0] t);
    logic signed [15:0] v;
    case (t)
      4'd0:    v = 16'sd16384;
      4'd1:    v = 16'sd16069;
      4'd2:    v = 16'sd15137;
      4'd3:    v = 16'sd13623;
      4'd4:    v = 16'sd11585;
      4'd5:    v = 16'sd9102;
      4'd6:    v = 16'sd6270;
      4'd7:    v = 16'sd3196;
      4'd8:    v = 16'sd0;
      4'd9:    v = -16'sd3196;
      4'd10:   v = -16'sd6270;
      4'd11:   v = -16'sd9102;
      4'd12:   v = -16'sd11585;
      4'd13:   v = -16'sd13623;
      4'd14:   v = -16'sd15137;
      4'd15:   v = -16'sd16069;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // sin(pi*t/16) in Q1.14, never negative
  function automatic logic [14:0] sin_q14(input logic [THETA_BITS-1:0] t);
    logic [14:0] v;
    case (t)
      4'd0:    v = 15'd0;
      4'd1:    v = 15'd3196;
      4'd2:    v = 15'd6270;
      4'd3:    v = 15'd9102;
      4'd4:    v = 15'd11585;
      4'd5:    v = 15'd13623;
      4'd6:    v = 15'd15137;
      4'd7:    v = 15'd16069;
      4'd8:    v = 15'd16384;
      4'd9:    v = 15'd16069;
      4'd10:   v = 15'd15137;
      4'd11:   v = 15'd13623;
      4'd12:   v = 15'd11585;
      4'd13:   v = 15'd9102;
      4'd14:   v = 15'd6270;
      4'd15:   v = 15'd3196;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/hlv_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_pix_if
// Input channel: edge pixel or find request.
// ----------------------------------------------------------------------------
interface hlv_pix_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [hlv_pkg::COORD_BITS-1:0]   pixel_row;
  logic [hlv_pkg::COORD_BITS-1:0]   pixel_col;
  logic [hlv_pkg::VAL_BITS-1:0]     pixel_value;

  modport source (output valid, kind, pixel_row, pixel_col, pixel_value, input ready);
  modport sink   (input valid, kind, pixel_row, pixel_col, pixel_value, output ready);
endinterface

// File: sv/hlv_peak_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_peak_if
// Output channel: one reported peak per transaction.
// ----------------------------------------------------------------------------
interface hlv_peak_if;
  logic                             valid;
  logic                             ready;
  logic                             peak_found;
  logic [hlv_pkg::THETA_BITS-1:0]   peak_theta_bin;
  logic [hlv_pkg::RHO_BITS-1:0]     peak_rho_bin;
  logic                             last;

  modport source (output valid, peak_found, peak_theta_bin, peak_rho_bin, last, input ready);
  modport sink   (input valid, peak_found, peak_theta_bin, peak_rho_bin, last, output ready);
endinterface

// File: sv/hlv_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface hlv_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [hlv_pkg::CFG_IDX_BITS-1:0]   index;
  logic [hlv_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/hlv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hlv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hlv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_ctrl
// Sequencer: clearing pass, vote issue, peak scan, flush.
// ----------------------------------------------------------------------------
module hlv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pix_valid_i,
  input  logic          pix_kind_i,
  output logic          pix_ready_o,
  input  hlv_pkg::sts_t sts_i,
  output hlv_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_e                          state_q, state_d;
  logic [hlv_pkg::THETA_BITS-1:0]  theta_q, theta_d;
  logic [hlv_pkg::RHO_BITS-1:0]    rho_q, rho_d;
  logic [hlv_pkg::STEP_BITS-1:0]   step_q, step_d;
  logic [hlv_pkg::ADDR_BITS-1:0]   clr_q, clr_d;
  logic [1:0]                      drain_q, drain_d;

  always_comb begin
    state_d     = state_q;
    theta_d     = theta_q;
    rho_d       = rho_q;
    step_d      = step_q;
    clr_d       = clr_q;
    drain_d     = drain_q;
    pix_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.vote_theta = theta_q;
    cmd_o.step       = step_q;
    cmd_o.cell_theta = theta_q;
    cmd_o.cell_rho   = rho_q;
    cmd_o.clr_addr   = clr_q;

    case (state_q)
      ST_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.pix_load = 1'b1;
          if (pix_kind_i == hlv_pkg::KIND_FIND) begin
            cmd_o.find_start = 1'b1;
            theta_d = hlv_pkg::THETA_BITS'(1);
            rho_d   = hlv_pkg::RHO_BITS'(1);
            step_d  = '0;
            state_d = ST_SCAN;
          end else begin
            theta_d = '0;
            state_d = ST_VOTE;
          end
        end
      end
      ST_VOTE: begin
        cmd_o.vote_en = 1'b1;
        if (theta_q == hlv_pkg::THETA_LAST) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          theta_d = theta_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (step_q != hlv_pkg::STEP_LAST) begin
          step_d = step_q + 1'b1;
        end else if (sts_i.peak && sts_i.pend_valid && !sts_i.can_push) begin
          // hold: the previous peak still waits for the output register
          step_d = step_q;
        end else if (sts_i.peak && sts_i.limit_next) begin
          cmd_o.take_peak = 1'b1;
          state_d = ST_FLUSH;
        end else begin
          cmd_o.take_peak = sts_i.peak;
          step_d = '0;
          if (rho_q == hlv_pkg::RHO_INNER) begin
            rho_d = hlv_pkg::RHO_BITS'(1);
            if (theta_q == hlv_pkg::THETA_INNER) begin
              state_d = ST_FLUSH;
            end else begin
              theta_d = theta_q + 1'b1;
            end
          end else begin
            rho_d = rho_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.can_push) begin
          cmd_o.flush = 1'b1;
          clr_d   = '0;
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (clr_q == hlv_pkg::ADDR_LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      theta_q <= '0;
      rho_q   <= '0;
      step_q  <= '0;
      clr_q   <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      theta_q <= theta_d;
      rho_q   <= rho_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      drain_q <= drain_d;
    end
  end

endmodule

// File: sv/hlv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlv_dp
// Datapath: config registers, rho pipeline, vote update, peak compare,
// pending peak and output register.
// ----------------------------------------------------------------------------
module hlv_dp #(
  parameter int unsigned COUNT_BITS = hlv_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [hlv_pkg::COORD_BITS-1:0]      pix_row_i,
  input  logic [hlv_pkg::COORD_BITS-1:0]      pix_col_i,
  input  logic [hlv_pkg::VAL_BITS-1:0]        pix_value_i,
  input  logic                                cfg_valid_i,
  input  logic [hlv_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [hlv_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  hlv_pkg::cmd_t                       cmd_i,
  output hlv_pkg::sts_t                       sts_o,
  output logic                                ram_we_o,
  output logic [hlv_pkg::ADDR_BITS-1:0]       ram_waddr_o,
  output logic [COUNT_BITS-1:0]               ram_wdata_o,
  output logic                                ram_re_o,
  output logic [hlv_pkg::ADDR_BITS-1:0]       ram_raddr_o,
  input  logic [COUNT_BITS-1:0]               ram_rdata_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_found_o,
  output logic [hlv_pkg::THETA_BITS-1:0]      out_theta_o,
  output logic [hlv_pkg::RHO_BITS-1:0]        out_rho_o,
  output logic                                out_last_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int unsigned TB = hlv_pkg::THETA_BITS;
  localparam int unsigned RB = hlv_pkg::RHO_BITS;

  // Configuration
  logic [hlv_pkg::VAL_BITS-1:0]   thresh_q;
  logic [hlv_pkg::LINES_BITS-1:0] max_lines_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= hlv_pkg::VAL_BITS'(3);
      max_lines_q <= hlv_pkg::LINES_BITS'(2);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == hlv_pkg::CFG_EDGE_THRESHOLD) begin
        thresh_q <= cfg_data_i[hlv_pkg::VAL_BITS-1:0];
      end else if (cfg_index_i == hlv_pkg::CFG_MAX_LINES) begin
        max_lines_q <= cfg_data_i[hlv_pkg::LINES_BITS-1:0];
      end
    end
  end

  // Pixel latch
  logic [hlv_pkg::COORD_BITS-1:0] row_q, col_q;
  logic                           qual_q;
  logic                           qual_d;

  assign qual_d = (pix_value_i != '0) && (pix_value_i >= thresh_q)
               && ({1'b0, pix_row_i} < 10'(hlv_pkg::IMG_SIZE))
               && ({1'b0, pix_col_i} < 10'(hlv_pkg::IMG_SIZE));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      row_q  <= pix_row_i;
      col_q  <= pix_col_i;
      qual_q <= qual_d;
    end
  end

  // Stage 1: products
  logic                  s1_valid_q, s2_valid_q, s3_valid_q;
  logic [TB-1:0]         s1_theta_q;
  logic signed [25:0]    s1_pc_q;
  logic [23:0]           s1_ps_q;

  always_ff @(posedge clk_i) begin
    s1_theta_q <= cmd_i.vote_theta;
    s1_pc_q    <= $signed({1'b0, col_q}) * hlv_pkg::cos_q14(cmd_i.vote_theta);
    s1_ps_q    <= row_q * hlv_pkg::sin_q14(cmd_i.vote_theta);
  end

  // Stage 2: rho, round to bin, range check
  logic signed [26:0] rho;
  logic        [26:0] mag;
  logic        [26:0] rnd;
  logic        [7:0]  shq;
  logic        [15:0] q3;
  logic        [6:0]  qb;
  logic               neg;
  logic               in_range;
  logic        [6:0]  bin7;
  logic [hlv_pkg::ADDR_BITS-1:0] s2_addr_q, s3_addr_q;

  always_comb begin
    rho      = $signed({s1_pc_q[25], s1_pc_q}) + $signed({3'b000, s1_ps_q});
    neg      = rho[26];
    mag      = neg ? 27'(-rho) : 27'(rho);
    rnd      = mag + 27'(hlv_pkg::RHO_ROUND);
    shq      = rnd[hlv_pkg::RHO_DEN_SHIFT +: 8];
    q3       = 16'(shq) * 16'(hlv_pkg::RECIP3);
    qb       = q3[hlv_pkg::RECIP3_SHIFT +: 7];
    in_range = neg ? (qb <= 7'(hlv_pkg::RHO_HALF))
                   : (qb < 7'(hlv_pkg::RHO_BINS - hlv_pkg::RHO_HALF));
    bin7     = neg ? 7'(hlv_pkg::RHO_HALF) - qb : 7'(hlv_pkg::RHO_HALF) + qb;
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q <= {s1_theta_q, bin7[RB-1:0]};
    s3_addr_q <= s2_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.vote_en && qual_q;
      s2_valid_q <= s1_valid_q && in_range;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Scan addressing: center first, then the eight neighbours
  logic [TB-1:0] nt;
  logic [RB-1:0] nr;

  always_comb begin
    nt = cmd_i.cell_theta;
    nr = cmd_i.cell_rho;
    case (cmd_i.step)
      4'd1: begin nt = cmd_i.cell_theta - 1'b1; nr = cmd_i.cell_rho - 1'b1; end
      4'd2: begin nt = cmd_i.cell_theta - 1'b1; end
      4'd3: begin nt = cmd_i.cell_theta - 1'b1; nr = cmd_i.cell_rho + 1'b1; end
      4'd4: begin nr = cmd_i.cell_rho - 1'b1; end
      4'd5: begin nr = cmd_i.cell_rho + 1'b1; end
      4'd6: begin nt = cmd_i.cell_theta + 1'b1; nr = cmd_i.cell_rho - 1'b1; end
      4'd7: begin nt = cmd_i.cell_theta + 1'b1; end
      4'd8: begin nt = cmd_i.cell_theta + 1'b1; nr = cmd_i.cell_rho + 1'b1; end
      default: begin
        nt = cmd_i.cell_theta;
        nr = cmd_i.cell_rho;
      end
    endcase
  end

  logic scan_re;
  assign scan_re     = cmd_i.scan_en && (cmd_i.step != hlv_pkg::STEP_LAST);
  assign ram_re_o    = s2_valid_q || scan_re;
  assign ram_raddr_o = s2_valid_q ? s2_addr_q : {nt, nr};

  // Vote write-back with saturation, or clear
  assign ram_we_o    = s3_valid_q || cmd_i.clr_en;
  assign ram_waddr_o = cmd_i.clr_en ? cmd_i.clr_addr : s3_addr_q;
  assign ram_wdata_o = cmd_i.clr_en ? '0
                     : ((ram_rdata_i == CNT_MAX) ? ram_rdata_i : ram_rdata_i + 1'b1);

  // Peak compare: data of read k arrives at step k+1
  logic [COUNT_BITS-1:0] center_q;
  logic                  flag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (cmd_i.step == 4'd1) begin
        center_q <= ram_rdata_i;
        flag_q   <= 1'b1;
      end else if (cmd_i.step != hlv_pkg::STEP_LAST) begin
        flag_q <= flag_q && (center_q > ram_rdata_i);
      end
    end
  end

  // Limit, pending peak and output register
  logic [hlv_pkg::LINES_BITS-1:0] limit;
  logic [hlv_pkg::LINES_BITS-1:0] count_q;
  logic                           pend_valid_q;
  logic [TB-1:0]                  pend_theta_q;
  logic [RB-1:0]                  pend_rho_q;
  logic                           can_push;
  logic                           push;

  assign limit = (max_lines_q == '0) ? hlv_pkg::LINES_BITS'(1)
               : ((max_lines_q > hlv_pkg::LINES_BITS'(hlv_pkg::RESULT_CAP))
                  ? hlv_pkg::LINES_BITS'(hlv_pkg::RESULT_CAP) : max_lines_q);

  assign can_push = !out_valid_o || out_ready_i;
  assign push     = (cmd_i.take_peak && pend_valid_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.find_start) begin
        count_q      <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.take_peak) begin
        count_q      <= count_q + 1'b1;
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_peak) begin
      pend_theta_q <= cmd_i.cell_theta;
      pend_rho_q   <= cmd_i.cell_rho;
    end
    if (push) begin
      out_found_o <= pend_valid_q;
      out_theta_o <= pend_valid_q ? pend_theta_q : '0;
      out_rho_o   <= pend_valid_q ? pend_rho_q : '0;
      out_last_o  <= cmd_i.flush;
    end
  end

  assign sts_o.peak       = flag_q && (center_q > ram_rdata_i);
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.can_push   = can_push;
  assign sts_o.limit_next = ({1'b0, count_q} + 8'd1) >= {1'b0, limit};
  assign sts_o.vote_busy  = s1_valid_q || s2_valid_q || s3_valid_q;

endmodule

// File: sv/hough_line_vote_and_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_line_vote_and_peak
// Hough line accumulator: edge pixels vote over 16 angle bins into a
// 16x64 counter store; a find request reports strict 8-neighbour peaks and
// then clears the store.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  pix_i    in   valid/ready    kind, pixel_row, pixel_col, pixel_value
//  peak_o   out  valid/ready    peak_found, peak_theta_bin, peak_rho_bin, last
//  cfg_i    in   valid/ready    index, data (always ready)
//
//  Vote item: accept, then 16 read-modify-write votes through the one
//  accumulator write port, then the pipeline drain.
//  Find item: nine reads per interior cell on the single read port, up to
//  14 x 62 cells, then a clearing pass over all 1024 cells; stalls on
//  peak_o hold the scan.
//  After reset the same clearing pass runs with pix_i not ready.
//  Results sit in an output register, so scanning goes on while a peak waits.
// ----------------------------------------------------------------------------
module hough_line_vote_and_peak #(
  parameter int unsigned COUNT_BITS = hlv_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hlv_pix_if.sink     pix_i,
  hlv_peak_if.source  peak_o,
  hlv_cfg_if.sink     cfg_i
);

  hlv_pkg::cmd_t cmd;
  hlv_pkg::sts_t sts;

  logic                          ram_we;
  logic [hlv_pkg::ADDR_BITS-1:0] ram_waddr;
  logic [COUNT_BITS-1:0]         ram_wdata;
  logic                          ram_re;
  logic [hlv_pkg::ADDR_BITS-1:0] ram_raddr;
  logic [COUNT_BITS-1:0]         ram_rdata;

  // Configuration writes take effect at once; the user must write only while idle, the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  // Sequencer: owns the vote, scan and clear counters and the accept decision
  hlv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_kind_i  (pix_i.kind),
    .pix_ready_o (pix_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: rho pipeline, compare, output register
  hlv_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_row_i   (pix_i.pixel_row),
    .pix_col_i   (pix_i.pixel_col),
    .pix_value_i (pix_i.pixel_value),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_ready_i (peak_o.ready),
    .out_valid_o (peak_o.valid),
    .out_found_o (peak_o.peak_found),
    .out_theta_o (peak_o.peak_theta_bin),
    .out_rho_o   (peak_o.peak_rho_bin),
    .out_last_o  (peak_o.last)
  );

  // Vote counter store, theta-major: address = {theta, rho bin}
  hlv_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (hlv_pkg::CELLS)
  ) u_votes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // Drop no input while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !pix_i.ready)
    else $error("input ready during clearing pass");

  // Clear writes never collide with vote write-back
  a_clear_vs_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !sts.vote_busy)
    else $error("clear overlaps vote pipeline");

  // A push never overwrites a result still waiting on peak_o
  a_push_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.take_peak && sts.pend_valid) || cmd.flush) |-> sts.can_push)
    else $error("result overwritten");

  // Flush always closes the find with a last transaction
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> (peak_o.valid && peak_o.last))
    else $error("flush without last result");
`endif

endmodule

// File: verif/hough_line_vote_and_peak_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_line_vote_and_peak_tb
// Self-checking bench for the Hough line accumulator. Edge pixels and find
// requests go in through a queued driver, peaks come out through a stalling
// monitor. A transaction-level software copy of the counter store, with its own
// trig tables, predicts every reported peak. Thresholds and line limits are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module hough_line_vote_and_peak_tb;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 1200;  // covers a clearing pass
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef struct packed {
    logic                           kind;
    logic [hlv_pkg::COORD_BITS-1:0] row;
    logic [hlv_pkg::COORD_BITS-1:0] col;
    logic [hlv_pkg::VAL_BITS-1:0]   mag;
  } pix_item_t;

  typedef struct packed {
    logic                           found;
    logic [hlv_pkg::THETA_BITS-1:0] theta;
    logic [hlv_pkg::RHO_BITS-1:0]   rho;
    logic                           last;
  } peak_item_t;

  logic clk;
  logic rst_n;

  hlv_pix_if  pix ();
  hlv_peak_if pk ();
  hlv_cfg_if  cfg ();

  hough_line_vote_and_peak dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .peak_o (pk),
    .cfg_i  (cfg)
  );

  // Clock and the single reset at the start of the run.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Predictor state: counter store, trig tables and the register copies.
  int unsigned vote_cnt[hlv_pkg::THETA_BINS][hlv_pkg::RHO_BINS];
  int          cos_tab[hlv_pkg::THETA_BINS];
  int          sin_tab[hlv_pkg::THETA_BINS];
  int unsigned thresh_reg;
  int unsigned lines_reg;

  pix_item_t  pix_q[$];
  peak_item_t peak_exp_q[$];
  pix_item_t  cur_pix;
  bit         cur_busy;
  int unsigned gap_left;
  bit          quiet;       // no idling on either side in the last phase
  bit          hold_armed;  // owned by the stimulus process
  bit          hold_done;   // owned by the ready process
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  function automatic int q30_to_q14(longint v);
    longint q;
    if (v < 0) v = 0;
    q = (v + 32768) >>> 16;
    if (q > 16384) q = 16384;
    return int'(q);
  endfunction

  // Fold the angle into the first quadrant, run a truncated Taylor series in
  // Q30, and round to Q1.14. Cosine changes sign beyond a right angle.
  function automatic void build_trig();
    longint unsigned pi_q30 = 64'd3373259426;
    longint unsigned one_q30 = 64'd1073741824;
    longint unsigned x, x2, mc, ms;
    longint c, s;
    bit fold;
    int unsigned k;
    for (int t = 0; t < hlv_pkg::THETA_BINS; t++) begin
      fold = (2 * t) > hlv_pkg::THETA_BINS;
      k = fold ? hlv_pkg::THETA_BINS - t : t;
      x = (pi_q30 * k) / hlv_pkg::THETA_BINS;
      x2 = (x * x) >> 30;
      mc = one_q30;
      ms = x;
      c = 0;
      s = 0;
      for (int n = 0; n < 14; n++) begin
        if (n % 2) begin
          c -= longint'(mc);
          s -= longint'(ms);
        end else begin
          c += longint'(mc);
          s += longint'(ms);
        end
        mc = ((mc * x2) >> 30) / ((2 * n + 1) * (2 * n + 2));
        ms = ((ms * x2) >> 30) / ((2 * n + 2) * (2 * n + 3));
      end
      cos_tab[t] = fold ? -q30_to_q14(c) : q30_to_q14(c);
      sin_tab[t] = q30_to_q14(s);
    end
  endfunction

  function automatic void clear_store();
    foreach (vote_cnt[t, r]) vote_cnt[t][r] = 0;
  endfunction

  function automatic bit strict_peak(int t, int r);
    for (int dt = -1; dt <= 1; dt++)
      for (int dr = -1; dr <= 1; dr++)
        if ((dt != 0 || dr != 0) && vote_cnt[t][r] <= vote_cnt[t + dt][r + dr])
          return 1'b0;
    return 1'b1;
  endfunction

  // Apply one accepted transaction: either cast votes, or scan for peaks,
  // queue the expected results and clear the store.
  function automatic void apply_pixel(pix_item_t it);
    longint den = longint'(hlv_pkg::RHO_STEP) * 16384;
    longint rho, mag, q, bin;
    int unsigned limit, found;
    peak_item_t pi;
    if (it.kind == hlv_pkg::KIND_VOTE) begin
      if (it.mag > 0 && it.mag >= thresh_reg) begin
        for (int t = 0; t < hlv_pkg::THETA_BINS; t++) begin
          rho = longint'(it.col) * cos_tab[t] + longint'(it.row) * sin_tab[t];
          mag = rho < 0 ? -rho : rho;
          q = (mag + den / 2) / den;
          bin = (rho < 0 ? -q : q) + hlv_pkg::RHO_BINS / 2;
          if (bin >= 0 && bin < hlv_pkg::RHO_BINS && vote_cnt[t][bin] < 32'hFFFF)
            vote_cnt[t][bin]++;
        end
      end
      return;
    end
    limit = lines_reg == 0 ? 1
          : (lines_reg > hlv_pkg::RESULT_CAP ? hlv_pkg::RESULT_CAP : lines_reg);
    found = 0;
    for (int t = 1; t < hlv_pkg::THETA_BINS - 1 && found < limit; t++) begin
      for (int r = 1; r < hlv_pkg::RHO_BINS - 1 && found < limit; r++) begin
        if (strict_peak(t, r)) begin
          pi.found = 1'b1;
          pi.theta = hlv_pkg::THETA_BITS'(t);
          pi.rho = hlv_pkg::RHO_BITS'(r);
          pi.last = 1'b0;
          peak_exp_q = {peak_exp_q, pi};
          found++;
        end
      end
    end
    if (found == 0) begin
      pi = '0;
      pi.last = 1'b1;
      peak_exp_q = {peak_exp_q, pi};
    end else begin
      peak_exp_q[$].last = 1'b1;
    end
    clear_store();
  endfunction

  task automatic report(string msg);
    err_cnt++;
    $display("mismatch: %s", msg);
  endtask

  // Input driver: present the next pending item at the falling edge, with
  // short random gaps between transactions.
  always @(negedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (!cur_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        pix.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 2);
        pix.valid <= 1'b0;
      end else if (pix_q.size() > 0) begin
        cur_pix = pix_q.pop_front();
        cur_busy = 1'b1;
        pix.kind <= cur_pix.kind;
        pix.pixel_row <= cur_pix.row;
        pix.pixel_col <= cur_pix.col;
        pix.pixel_value <= cur_pix.mag;
        pix.valid <= 1'b1;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Input acceptance: feed the predictor on each transaction.
  always @(posedge clk) begin
    if (rst_n && pix.valid && pix.ready) begin
      apply_pixel(cur_pix);
      cur_busy = 1'b0;
    end
  end

  // Output ready: random stall bursts, plus one long hold-off once armed so
  // the output register backs up and scanning stalls.
  always @(negedge clk) begin
    if (hold_armed && !hold_done && pk.valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pk.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pk.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      pk.ready <= 1'b0;
    end else begin
      pk.ready <= 1'b1;
    end
  end

  // Output monitor: compare each peak transaction with the oldest expectation.
  always @(posedge clk) begin
    peak_item_t want;
    if (rst_n && pk.valid && pk.ready) begin
      if (peak_exp_q.size() == 0) begin
        report($sformatf("unexpected peak transaction theta %0d rho %0d",
                         pk.peak_theta_bin, pk.peak_rho_bin));
      end else begin
        want = peak_exp_q.pop_front();
        if (pk.peak_found !== want.found)
          report($sformatf("peak_found got %0d, expected %0d", pk.peak_found, want.found));
        if (pk.peak_theta_bin !== want.theta)
          report($sformatf("peak_theta_bin got %0d, expected %0d",
                           pk.peak_theta_bin, want.theta));
        if (pk.peak_rho_bin !== want.rho)
          report($sformatf("peak_rho_bin got %0d, expected %0d", pk.peak_rho_bin, want.rho));
        if (pk.last !== want.last)
          report($sformatf("last got %0d, expected %0d", pk.last, want.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_vote(int unsigned r, int unsigned c, int unsigned m);
    pix_item_t it;
    it.kind = hlv_pkg::KIND_VOTE;
    it.row = hlv_pkg::COORD_BITS'(r);
    it.col = hlv_pkg::COORD_BITS'(c);
    it.mag = hlv_pkg::VAL_BITS'(m);
    pix_q = {pix_q, it};
  endtask

  // Find items carry random payload bits that the block must ignore.
  task automatic add_find();
    pix_item_t it;
    it.kind = hlv_pkg::KIND_FIND;
    it.row = hlv_pkg::COORD_BITS'($urandom);
    it.col = hlv_pkg::COORD_BITS'($urandom);
    it.mag = hlv_pkg::VAL_BITS'($urandom);
    pix_q = {pix_q, it};
  endtask

  // Drain: all items accepted, all peaks back, then let the clearing pass
  // finish before touching the registers.
  task automatic settle();
    while (pix_q.size() > 0 || cur_busy || peak_exp_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [hlv_pkg::CFG_IDX_BITS-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data <= hlv_pkg::CFG_DATA_BITS'(value);
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    if (idx == hlv_pkg::CFG_EDGE_THRESHOLD) thresh_reg = value & 16'hFFFF;
    else if (idx == hlv_pkg::CFG_MAX_LINES) lines_reg = value & 7'h7F;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Points along a short straight segment, strong enough to form peaks.
  task automatic add_segment(int unsigned n);
    int x, y, dx, dy;
    x = $urandom_range(0, 511);
    y = $urandom_range(0, 511);
    dx = $urandom_range(0, 8) - 4;
    dy = $urandom_range(0, 8) - 4;
    for (int i = 0; i < n; i++) begin
      add_vote((y + i * dy) & 511, (x + i * dx) & 511,
               $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(thresh_reg, 65535));
    end
  endtask

  initial begin
    build_trig();
    clear_store();
    thresh_reg = 3;
    lines_reg = 2;
    cur_busy = 1'b0;
    gap_left = 0;
    quiet = 1'b0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stall_left = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    pix.valid = 1'b0;
    pix.kind = hlv_pkg::KIND_VOTE;
    pix.pixel_row = '0;
    pix.pixel_col = '0;
    pix.pixel_value = '0;
    pk.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = hlv_pkg::CFG_EDGE_THRESHOLD;
    cfg.data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset register values: find on an empty store, zero and
    // sub-threshold magnitudes, corner pixels, repeated pixel for a peak.
    add_find();
    add_vote(5, 5, 0);
    add_vote(5, 5, 2);
    add_vote(0, 0, 3);
    add_vote(511, 511, 65535);
    add_vote(0, 511, 7);
    add_vote(511, 0, 100);
    add_vote(200, 300, 50);
    add_vote(200, 300, 50);
    add_vote(200, 300, 50);
    add_find();
    settle();

    // Zero threshold still rejects zero magnitude; widest line limit.
    write_reg(hlv_pkg::CFG_EDGE_THRESHOLD, 0);
    write_reg(hlv_pkg::CFG_MAX_LINES, 64);
    add_vote(10, 10, 0);
    add_vote(10, 10, 1);
    add_segment(6);
    add_find();
    settle();

    // Top threshold, and a line limit of zero which acts as one.
    write_reg(hlv_pkg::CFG_EDGE_THRESHOLD, 65535);
    write_reg(hlv_pkg::CFG_MAX_LINES, 0);
    add_vote(100, 100, 65534);
    add_vote(100, 100, 65535);
    add_vote(100, 100, 65535);
    add_find();
    settle();

    // Random phases: mostly line segments, some scattered pixels, each phase
    // closed by a find. Upper data bits are random to check the masking.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(hlv_pkg::CFG_EDGE_THRESHOLD,
                ph == 3 ? 65535 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 300)));
      case (ph)
        1:       write_reg(hlv_pkg::CFG_MAX_LINES, 127);
        2:       write_reg(hlv_pkg::CFG_MAX_LINES, 1);
        4:       write_reg(hlv_pkg::CFG_MAX_LINES, 64);
        default: write_reg(hlv_pkg::CFG_MAX_LINES, $urandom);
      endcase
      if (ph == 4) hold_armed = 1'b1;
      if (ph == 11) quiet = 1'b1;
      for (int k = 0; k < 2; k++) begin
        add_segment($urandom_range(6, 10));
        for (int j = 0; j < 3; j++)
          add_vote($urandom_range(0, 511), $urandom_range(0, 511), $urandom);
        add_find();
      end
      settle();
    end

    if (peak_exp_q.size() > 0) begin
      report($sformatf("%0d expected peaks never arrived", peak_exp_q.size()));
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
